// File: design/vt100_pkg.sv
package vt100_pkg;

   // Byte codes that steer the decoder.
   localparam logic [7:0] CHAR_NUL     = 8'h00;
   localparam logic [7:0] CHAR_BS      = 8'h08;
   localparam logic [7:0] CHAR_LF      = 8'h0A;
   localparam logic [7:0] CHAR_CR      = 8'h0D;
   localparam logic [7:0] CHAR_ESC     = 8'h1B;
   localparam logic [7:0] CHAR_BRACKET = 8'h5B;
   localparam logic [7:0] CHAR_TILDE   = 8'h7E;
   localparam logic [7:0] CHAR_ZERO    = 8'h30;
   localparam logic [7:0] CHAR_NINE    = 8'h39;
   localparam logic [7:0] CHAR_UPPER_A = 8'h41;
   localparam logic [7:0] CHAR_UPPER_D = 8'h44;

   // Escape phase codes.
   localparam logic [1:0] PH_IDLE    = 2'd0;
   localparam logic [1:0] PH_ESC     = 2'd1;
   localparam logic [1:0] PH_BRACKET = 2'd2;
   localparam logic [1:0] PH_NUMBER  = 2'd3;

   // Key codes with a fixed meaning.
   localparam logic [4:0] KEY_NONE      = 5'd0;
   localparam logic [4:0] KEY_BACKSPACE = 5'd0;

   // Saturation limit of the collected number.
   localparam logic [11:0] NUMBER_MAX = 12'd255;

   typedef struct packed {
      logic [1:0] phase;
      logic [7:0] number;
   } esc_state_type;

   typedef struct packed {
      logic       emit;
      logic       is_key;
      logic [7:0] char_value;
      logic [4:0] key_code;
   } dec_result_type;

   // Maps the number of an ESC [ n ~ sequence to a key code; zero means unknown.
   function automatic logic [4:0] number_key(input logic [7:0] number);
      logic [4:0] key;
      key = KEY_NONE;
      case (number)
         8'd1:  key = 5'd5;
         8'd2:  key = 5'd6;
         8'd3:  key = 5'd9;
         8'd4:  key = 5'd7;
         8'd5:  key = 5'd8;
         8'd6:  key = 5'd10;
         8'd11: key = 5'd11;
         8'd12: key = 5'd12;
         8'd13: key = 5'd13;
         8'd14: key = 5'd14;
         8'd15: key = 5'd15;
         8'd17: key = 5'd16;
         8'd18: key = 5'd17;
         8'd19: key = 5'd18;
         8'd20: key = 5'd19;
         8'd21: key = 5'd20;
         8'd23: key = 5'd21;
         8'd24: key = 5'd22;
         default: key = KEY_NONE;
      endcase
      return key;
   endfunction

endpackage

// File: design/vt100_dec.sv
module vt100_dec (
   input  logic [7:0]                 rx_byte,
   input  vt100_pkg::esc_state_type   state_cur,
   output vt100_pkg::esc_state_type   state_nxt,
   output vt100_pkg::dec_result_type  result
);
   import vt100_pkg::*;

   logic        is_digit;
   logic        is_arrow;
   logic [3:0]  digit;
   logic [11:0] number_sum;
   logic [7:0]  number_sat;
   logic [4:0]  tilde_key;

   // Classify the byte and build the next number value.
   assign is_digit   = (rx_byte >= CHAR_ZERO) && (rx_byte <= CHAR_NINE);
   assign is_arrow   = (rx_byte >= CHAR_UPPER_A) && (rx_byte <= CHAR_UPPER_D);
   assign digit      = 4'(rx_byte - CHAR_ZERO);
   assign number_sum = {4'd0, state_cur.number} * 12'd10 + {8'd0, digit};
   assign number_sat = (number_sum > NUMBER_MAX) ? 8'hFF : number_sum[7:0];
   assign tilde_key  = number_key(state_cur.number);

   // Decode one byte against the escape state.
   always_comb begin
      state_nxt = state_cur;
      result    = '0;
      if ((rx_byte == CHAR_NUL) || (rx_byte == CHAR_LF)) begin
         result.emit = 1'b0;
      end else if (rx_byte == CHAR_CR) begin
         result.emit       = 1'b1;
         result.char_value = CHAR_LF;
      end else if (rx_byte == CHAR_BS) begin
         result.emit     = 1'b1;
         result.is_key   = 1'b1;
         result.key_code = KEY_BACKSPACE;
      end else if (rx_byte == CHAR_ESC) begin
         state_nxt.phase  = PH_ESC;
         state_nxt.number = 8'd0;
      end else begin
         case (state_cur.phase)
            PH_IDLE: begin
               result.emit       = 1'b1;
               result.char_value = rx_byte;
            end
            PH_ESC: begin
               state_nxt.phase = (rx_byte == CHAR_BRACKET) ? PH_BRACKET : PH_IDLE;
            end
            PH_BRACKET: begin
               if (is_arrow) begin
                  state_nxt.phase = PH_IDLE;
                  result.emit     = 1'b1;
                  result.is_key   = 1'b1;
                  result.key_code = 5'(rx_byte - CHAR_UPPER_A) + 5'd1;
               end else if (is_digit) begin
                  state_nxt.phase  = PH_NUMBER;
                  state_nxt.number = {4'd0, digit};
               end else begin
                  state_nxt.phase = PH_IDLE;
               end
            end
            default: begin
               if (is_digit) begin
                  state_nxt.number = number_sat;
               end else if (rx_byte == CHAR_TILDE) begin
                  state_nxt.phase = PH_IDLE;
                  if (tilde_key != KEY_NONE) begin
                     result.emit     = 1'b1;
                     result.is_key   = 1'b1;
                     result.key_code = tilde_key;
                  end
               end
            end
         endcase
      end
   end

endmodule

// File: design/vt100_key_sequence_decoder.sv
// VT100 key sequence decoder.
//
// The request channel (req_valid, req_stall, req_rx_byte) takes one terminal
// byte per transaction. The response channel (rsp_valid, rsp_stall and the
// rsp_ fields) gives at most one result per byte: a plain character, or a
// key code when rsp_is_key is high. Bytes that end in no result (NUL, LF,
// escape prefixes, unknown sequences) give no response transaction.
//
// A byte is captured in an input register, decoded combinationally against
// the escape state, and its result lands in the response register, so a
// result passes through both registers before it is on the response ports.
// One byte is taken every cycle as long as the response side keeps up; the
// combinational decode and state update between the two registers set that rate.
//
// Reset is synchronous and active high; it empties both registers and puts
// the escape state back to idle with the number cleared. While the receiver
// stalls a pending result, the response holds steady and the byte waiting
// in the input register stays there; req_stall rises only when that register
// is full and cannot move on.
module vt100_key_sequence_decoder (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_rx_byte,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic       rsp_is_key,
   output logic [7:0] rsp_char_value,
   output logic [4:0] rsp_key_code
);
   import vt100_pkg::*;

   logic           in_valid_ff;
   logic           in_valid_in;
   logic [7:0]     in_byte_ff;
   logic [7:0]     in_byte_in;
   esc_state_type  state_ff;
   esc_state_type  state_in;
   esc_state_type  state_nxt;
   dec_result_type dec_result;
   logic           rsp_valid_ff;
   logic           rsp_valid_in;
   logic           rsp_is_key_ff;
   logic           rsp_is_key_in;
   logic [7:0]     rsp_char_ff;
   logic [7:0]     rsp_char_in;
   logic [4:0]     rsp_key_ff;
   logic [4:0]     rsp_key_in;
   logic           out_free;
   logic           dec_fire;
   logic           req_take;

   vt100_dec u_dec (
      .rx_byte   (in_byte_ff),
      .state_cur (state_ff),
      .state_nxt (state_nxt),
      .result    (dec_result)
   );

   // Flow control between the input register and the response register.
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign dec_fire  = in_valid_ff && out_free;
   assign req_stall = in_valid_ff && !out_free;
   assign req_take  = req_valid && !req_stall;

   // Next values of the input register and the escape state.
   always_comb begin
      in_valid_in = in_valid_ff;
      in_byte_in  = in_byte_ff;
      state_in    = state_ff;
      if (dec_fire) begin
         in_valid_in = 1'b0;
         state_in    = state_nxt;
      end
      if (req_take) begin
         in_valid_in = 1'b1;
         in_byte_in  = req_rx_byte;
      end
   end

   // Next values of the response register.
   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_is_key_in = rsp_is_key_ff;
      rsp_char_in   = rsp_char_ff;
      rsp_key_in    = rsp_key_ff;
      if (out_free) begin
         rsp_valid_in = dec_fire && dec_result.emit;
      end
      if (dec_fire && dec_result.emit) begin
         rsp_is_key_in = dec_result.is_key;
         rsp_char_in   = dec_result.char_value;
         rsp_key_in    = dec_result.key_code;
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         state_ff     <= '{phase: PH_IDLE, number: 8'd0};
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         state_ff     <= state_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      in_byte_ff    <= in_byte_in;
      rsp_is_key_ff <= rsp_is_key_in;
      rsp_char_ff   <= rsp_char_in;
      rsp_key_ff    <= rsp_key_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_is_key     = rsp_is_key_ff;
   assign rsp_char_value = rsp_char_ff;
   assign rsp_key_code   = rsp_key_ff;

endmodule

// File: verif/tb.sv
`timescale 1ns / 100ps

module tb;
   import vt100_pkg::*;

   localparam logic [7:0] CHAR_NOISE = 8'h71;
   localparam int WATCHDOG_LIMIT = 5000;
   localparam int DRAIN_CYCLES   = 10;
   localparam int MAX_PRINTED    = 50;

   typedef struct packed {
      logic       is_key;
      logic [7:0] char_value;
      logic [4:0] key_code;
   } key_result_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   logic [7:0] req_rx_byte = 8'h00;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic       rsp_is_key;
   logic [7:0] rsp_char_value;
   logic [4:0] rsp_key_code;

   // Predictor state: a private copy of the escape state.
   logic [1:0] dec_phase = PH_IDLE;
   logic [7:0] dec_number = 8'd0;

   key_result_type pending_keys[$];
   int             error_count = 0;
   int             bytes_sent = 0;
   int             send_idle_pct = 0;
   int             stall_pct = 0;
   int             quiet_cycles = 0;

   vt100_key_sequence_decoder dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_rx_byte    (req_rx_byte),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_is_key     (rsp_is_key),
      .rsp_char_value (rsp_char_value),
      .rsp_key_code   (rsp_key_code)
   );

   always #10 clock = ~clock;

   // Key code for the number of an ESC [ n ~ sequence; zero means no key.
   function automatic logic [4:0] key_for_number(input logic [7:0] n);
      if (n >= 8'd1 && n <= 8'd2) return 5'(n + 8'd4);
      if (n == 8'd3) return 5'd9;
      if (n >= 8'd4 && n <= 8'd5) return 5'(n + 8'd3);
      if (n == 8'd6) return 5'd10;
      if (n >= 8'd11 && n <= 8'd15) return 5'(n);
      if (n >= 8'd17 && n <= 8'd21) return 5'(n - 8'd1);
      if (n >= 8'd23 && n <= 8'd24) return 5'(n - 8'd2);
      return KEY_NONE;
   endfunction

   // Advances the escape state by one byte; returns 1 when the byte yields a result.
   function automatic logic decode_byte(input logic [7:0] b, output key_result_type r);
      logic [11:0] grown;
      r = '0;
      if (b == CHAR_NUL || b == CHAR_LF) return 1'b0;
      if (b == CHAR_CR) begin
         r.char_value = CHAR_LF;
         return 1'b1;
      end
      if (b == CHAR_BS) begin
         r.is_key = 1'b1;
         r.key_code = KEY_BACKSPACE;
         return 1'b1;
      end
      if (b == CHAR_ESC) begin
         dec_phase = PH_ESC;
         dec_number = 8'd0;
         return 1'b0;
      end
      case (dec_phase)
         PH_IDLE: begin
            r.char_value = b;
            return 1'b1;
         end
         PH_ESC: begin
            dec_phase = (b == CHAR_BRACKET) ? PH_BRACKET : PH_IDLE;
            return 1'b0;
         end
         PH_BRACKET: begin
            if (b >= CHAR_UPPER_A && b <= CHAR_UPPER_D) begin
               dec_phase = PH_IDLE;
               r.is_key = 1'b1;
               r.key_code = 5'(b - CHAR_UPPER_A + 8'd1);
               return 1'b1;
            end
            if (b >= CHAR_ZERO && b <= CHAR_NINE) begin
               dec_phase = PH_NUMBER;
               dec_number = b - CHAR_ZERO;
            end else begin
               dec_phase = PH_IDLE;
            end
            return 1'b0;
         end
         default: begin
            if (b >= CHAR_ZERO && b <= CHAR_NINE) begin
               grown = 12'(dec_number) * 12'd10 + 12'(b - CHAR_ZERO);
               dec_number = (grown > 12'd255) ? 8'd255 : grown[7:0];
               return 1'b0;
            end
            if (b == CHAR_TILDE) begin
               dec_phase = PH_IDLE;
               r.is_key = 1'b1;
               r.key_code = key_for_number(dec_number);
               return r.key_code != KEY_NONE;
            end
            return 1'b0;
         end
      endcase
   endfunction

   task automatic report_mismatch(input string msg);
      if (error_count < MAX_PRINTED)
         $display("tb: mismatch at %0t: %s", $realtime, msg);
      error_count++;
   endtask

   // Offers one byte, waits for its transaction, then records what it should produce.
   task automatic send_byte(input logic [7:0] b);
      key_result_type r;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_rx_byte <= b;
      do @(posedge clock); while (req_stall);
      bytes_sent++;
      if (decode_byte(b, r))
         pending_keys.push_back(r);
   endtask

   task automatic send_number_sequence(input int value, input int noise_pct, input bit close);
      logic [7:0] noise;
      int         digits[3];
      int         count;
      count = 0;
      if (value >= 100) begin
         digits[count] = value / 100;
         count = count + 1;
      end
      if (value >= 10) begin
         digits[count] = (value / 10) % 10;
         count = count + 1;
      end
      digits[count] = value % 10;
      count = count + 1;
      send_byte(CHAR_ESC);
      send_byte(CHAR_BRACKET);
      if ($urandom_range(9) == 0)
         send_byte(CHAR_ZERO);
      for (int i = 0; i < count; i++) begin
         send_byte(CHAR_ZERO + 8'(digits[i]));
         // Stray bytes inside the number must not end the sequence.
         if ($urandom_range(99) < noise_pct) begin
            noise = 8'($urandom_range(255));
            if (noise == CHAR_ESC || noise == CHAR_TILDE ||
                (noise >= CHAR_ZERO && noise <= CHAR_NINE))
               noise = CHAR_NOISE;
            send_byte(noise);
         end
      end
      if (close)
         send_byte(CHAR_TILDE);
   endtask

   // Sets how often the sender idles and the receiver stalls, in percent.
   task automatic set_idling(input int send_pct, input int recv_pct);
      send_idle_pct = send_pct;
      stall_pct = recv_pct;
   endtask

   task automatic test_control_bytes();
      send_byte(CHAR_NUL);
      send_byte(CHAR_LF);
      send_byte(CHAR_CR);
      send_byte(CHAR_BS);
      send_byte(8'hFF);
      send_byte(CHAR_UPPER_A);
   endtask

   // An ESC inside a sequence starts over, then an arrow completes it.
   task automatic test_restart_and_arrow();
      send_byte(CHAR_ESC);
      send_byte(CHAR_BRACKET);
      send_byte(8'h31);
      send_byte(CHAR_ESC);
      send_byte(CHAR_BRACKET);
      send_byte(CHAR_UPPER_A);
   endtask

   // Broken prefixes are dropped along with the byte that broke them.
   task automatic test_broken_prefixes();
      send_byte(CHAR_ESC);
      send_byte(8'h78);
      send_byte(CHAR_ESC);
      send_byte(CHAR_BRACKET);
      send_byte(8'h7A);
   endtask

   // Saturated number, then a control byte and a letter inside a number that maps to F12.
   task automatic test_number_edges();
      send_number_sequence(300, 0, 1'b1);
      send_byte(CHAR_ESC);
      send_byte(CHAR_BRACKET);
      send_byte(8'h32);
      send_byte(CHAR_NOISE);
      send_byte(CHAR_CR);
      send_byte(8'h34);
      send_byte(CHAR_TILDE);
   endtask

   task automatic test_random_stream(input int target);
      int first;
      int pick;
      int value;
      first = bytes_sent;
      while (bytes_sent - first < target) begin
         pick = $urandom_range(99);
         if (pick < 30) begin
            pick = $urandom_range(99);
            if (pick < 60) value = $urandom_range(25);
            else if (pick < 85) value = $urandom_range(26, 99);
            else value = $urandom_range(100, 999);
            send_number_sequence(value, 15, $urandom_range(9) != 0);
         end else if (pick < 50) begin
            send_byte(CHAR_ESC);
            send_byte(CHAR_BRACKET);
            send_byte(8'($urandom_range(CHAR_UPPER_A, CHAR_UPPER_D)));
         end else if (pick < 75) begin
            send_byte(8'($urandom_range(255)));
         end else if (pick < 85) begin
            case ($urandom_range(3))
               0: send_byte(CHAR_NUL);
               1: send_byte(CHAR_LF);
               2: send_byte(CHAR_CR);
               default: send_byte(CHAR_BS);
            endcase
         end else if (pick < 95) begin
            send_byte(CHAR_ESC);
            if ($urandom_range(1)) send_byte(CHAR_BRACKET);
            send_byte(8'($urandom_range(255)));
         end else begin
            send_byte(CHAR_ESC);
         end
      end
   endtask

   // Receiver stalls at the rate of the current phase.
   always @(posedge clock) begin
      rsp_stall <= reset ? 1'b0 : ($urandom_range(99) < stall_pct);
   end

   // Each result transaction is checked against the oldest expected key.
   always @(posedge clock) begin
      key_result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_keys.size() == 0) begin
            report_mismatch($sformatf("unexpected result key=%0b char=%h code=%0d",
                                      rsp_is_key, rsp_char_value, rsp_key_code));
         end else begin
            want = pending_keys.pop_front();
            if (rsp_is_key !== want.is_key)
               report_mismatch($sformatf("is_key %0b, expected %0b", rsp_is_key, want.is_key));
            if (rsp_char_value !== want.char_value)
               report_mismatch($sformatf("char_value %h, expected %h",
                                         rsp_char_value, want.char_value));
            if (rsp_key_code !== want.key_code)
               report_mismatch($sformatf("key_code %0d, expected %0d",
                                         rsp_key_code, want.key_code));
         end
      end
   end

   // Watchdog on cycles with no transaction on either channel.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("tb: done, errors");
            $finish;
         end
      end
   end

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_control_bytes();
      test_restart_and_arrow();
      test_broken_prefixes();
      test_number_edges();

      set_idling(0, 0);
      test_random_stream(125);
      set_idling(72, 0);
      test_random_stream(125);
      set_idling(0, 72);
      test_random_stream(125);
      set_idling(6, 6);
      test_random_stream(125);

      req_valid <= 1'b0;
      while (pending_keys.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (error_count == 0) begin
         $display("tb: done, clean");
      end else begin
         $display("tb: done, errors");
      end
      $finish;
   end

endmodule
